// ===== sv/ssf_pkg.sv =====
package ssf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

	localparam int WREG_W    = 9;
	localparam int GAIN_W    = 17;
	localparam int FRAC_BITS = 16;

	localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;
	localparam logic [WREG_W-1:0] WIN_RESET  = 9'd16;

	localparam logic MODE_AVG = 1'b0;
	localparam logic MODE_EXP = 1'b1;

endpackage

// ===== sv/selectable_smoothing_filter.sv =====
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: sample, tuser: restart
// m_axis    out  m_axis_tvalid/tready      tdata: filtered
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// How long a result takes after its sample is set by the bit-serial divider; the 17-step serial
// multiply runs beside it. s_axis_tready is high only while no sample is in work, so a new
// sample is not taken before the last one is through; a finished result waits in the output
// register and the next sample is taken meanwhile. A new result stalls in ST_FIN while the
// previous one is not yet taken.
// Reset clears control, config and filter state; history RAM is not cleared.
module selectable_smoothing_filter #(
	parameter int MAX_WINDOW  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
	input  logic                               s_axis_tuser,  // [0] restart
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,  // [SAMPLE_BITS-1:0] filtered
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import ssf_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PTR_W   = $clog2(MAX_WINDOW);
	localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W   = (WIN_W > WREG_W) ? WIN_W : WREG_W;
	localparam int SUM_W   = SAMPLE_BITS + PTR_W;
	localparam int SM_W    = SAMPLE_BITS + FRAC_BITS;
	localparam int D_W     = SM_W + 1;
	localparam int PROD_W  = D_W + GAIN_W + 1;
	localparam int MCNT_W  = $clog2(GAIN_W + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUB  = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                    state_q;
	logic                          mode_q;
	logic [WREG_W-1:0]             wreg_q;
	logic [GAIN_W-1:0]             gain_q;

	logic [SAMPLE_BITS-1:0]        history [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0]        rd_q;
	logic [PTR_W-1:0]              wp_q;
	logic [WIN_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SM_W-1:0]        sm_q;
	logic                          seeded_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          restart_q;
	logic                          seed_q;
	logic                          neg_q;
	logic signed [D_W-1:0]         d_q;
	logic [GAIN_W-1:0]             g_q;
	logic signed [PROD_W-1:0]      acc_q;
	logic [MCNT_W-1:0]             mcnt_q;

	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_q;

	logic [WIN_W-1:0]              w_eff;
	logic [CMP_W-1:0]              wext;
	logic [GAIN_W-1:0]             g_eff;
	logic [PTR_W-1:0]              wp_eff;
	logic [PTR_W:0]                ra_sum;
	logic [PTR_W-1:0]              ra;
	logic signed [SUM_W-1:0]       old_term;
	logic signed [SUM_W-1:0]       sum_new;
	logic [SUM_W-1:0]              sum_abs;
	logic                          div_start;
	logic                          div_busy;
	logic [SUM_W-1:0]              quot;
	logic signed [PROD_W-1:0]      rnd;
	logic signed [SM_W:0]          y_t;
	logic signed [SAMPLE_BITS:0]   y_w;
	logic [SAMPLE_BITS-1:0]        y_sat;
	logic [SAMPLE_BITS-1:0]        avg;
	logic                          in_xfer;
	logic                          out_load;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		wext = CMP_W'(wreg_q);
		if (wext == '0) begin
			w_eff = WIN_W'(1);
		end else if (wext > CMP_W'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = wext[WIN_W-1:0];
		end
	end

	assign g_eff = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

	// oldest sample leaving the window
	assign wp_eff = s_axis_tuser ? '0 : wp_q;
	assign ra_sum = (PTR_W+1)'(wp_eff) + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(w_eff);
	assign ra     = (ra_sum >= (PTR_W+1)'(MAX_WINDOW)) ?
	                PTR_W'(ra_sum - (PTR_W+1)'(MAX_WINDOW)) : ra_sum[PTR_W-1:0];

	assign old_term = (fill_q >= w_eff) ? SUM_W'(signed'(rd_q)) : '0;
	assign sum_new  = sum_q + SUM_W'(x_q) - old_term;
	assign sum_abs  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
	assign div_start = (state_q == ST_SUB);

	ssf_serial_div #(
		.DVD_W (SUM_W),
		.DVS_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs),
		.divisor  (w_eff),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign rnd = (acc_q + PROD_W'(32768)) >>> FRAC_BITS;

	assign y_t = SM_W'(sm_q) + (SM_W+1)'(32768);
	assign y_w = y_t[SM_W:FRAC_BITS];
	always_comb begin
		if (y_w > (SAMPLE_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1)) begin
			y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (y_w < -(SAMPLE_BITS+1)'(1 << (SAMPLE_BITS - 1))) begin
			y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y_sat = y_w[SAMPLE_BITS-1:0];
		end
	end

	assign avg = neg_q ? SAMPLE_BITS'(-quot[SAMPLE_BITS-1:0]) : quot[SAMPLE_BITS-1:0];

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_AVG;
			wreg_q      <= WIN_RESET;
			gain_q      <= GAIN_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sm_q        <= '0;
			seeded_q    <= 1'b0;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_WINDOW: begin
						wreg_q <= cfg_data[WREG_W-1:0];
						wp_q   <= '0;
						fill_q <= '0;
						sum_q  <= '0;
					end
					CFG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (mcnt_q != '0) begin
				mcnt_q <= mcnt_q - 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser) begin
							wp_q   <= '0;
							fill_q <= '0;
							sum_q  <= '0;
						end
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					sum_q  <= sum_new;
					wp_q   <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
					if (fill_q < WIN_W'(MAX_WINDOW)) begin
						fill_q <= fill_q + 1'b1;
					end
					if (restart_q || !seeded_q) begin
						sm_q     <= SM_W'(x_q) <<< FRAC_BITS;
						seeded_q <= 1'b1;
					end else begin
						mcnt_q <= MCNT_W'(GAIN_W);
					end
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (!div_busy && mcnt_q == '0) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (!seed_q) begin
						sm_q <= SM_W'(PROD_W'(sm_q) + rnd);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_q      <= history[ra];
			x_q       <= s_axis_tdata[SAMPLE_BITS-1:0];
			restart_q <= s_axis_tuser;
		end
		if (state_q == ST_SUB) begin
			history[wp_q] <= x_q;
			neg_q         <= sum_new[SUM_W-1];
			seed_q        <= restart_q || !seeded_q;
			d_q           <= (D_W'(x_q) <<< FRAC_BITS) - D_W'(sm_q);
			g_q           <= g_eff;
			acc_q         <= '0;
		end else if (mcnt_q != '0) begin
			// gain MSB first, shift and add
			acc_q <= (acc_q <<< 1) + (g_q[GAIN_W-1] ? PROD_W'(d_q) : '0);
			g_q   <= {g_q[GAIN_W-2:0], 1'b0};
		end
		if (out_load) begin
			out_q <= (mode_q == MODE_EXP) ? y_sat : avg;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_q);

endmodule

// ===== sv/ssf_serial_div.sv =====
module ssf_serial_div #(
	parameter int DVD_W = 24,
	parameter int DVS_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

// ===== test/selectable_smoothing_filter_tb.sv =====
`timescale 1ns / 1ps

module selectable_smoothing_filter_tb;
	import ssf_pkg::*;

	typedef struct packed {
		logic signed [15:0] pcm;
		logic               restart;
	} pcm_item_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// filter state as the block should hold it
	logic                  mode_reg  = MODE_AVG;
	logic [WREG_W-1:0]     win_reg   = WIN_RESET;
	logic [GAIN_W-1:0]     gain_reg  = GAIN_RESET;
	logic signed [15:0]    hist [256];
	logic [7:0]            wr_pos    = '0;
	logic [8:0]            fill_cnt  = '0;
	logic signed [23:0]    run_sum   = '0;
	logic signed [31:0]    exp_state = '0;
	logic                  seeded    = 1'b0;

	pcm_item_t             pending_pcm[$];
	logic [15:0]           expected_filtered[$];
	int                    mismatches = 0;
	int                    in_gap     = 0;
	int                    out_stall  = 0;
	bit                    in_taken   = 1'b0;
	bit                    allow_idle = 1'b0;

	selectable_smoothing_filter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_history();
		wr_pos   = '0;
		fill_cnt = '0;
		run_sum  = '0;
	endfunction

	function automatic logic [15:0] filter_step(input logic signed [15:0] x, input logic rst);
		longint     w;
		longint     g;
		longint     d;
		longint     avg;
		longint     y;
		logic [7:0] old_pos;
		w = (win_reg == 0) ? 1 : ((win_reg > 256) ? 256 : longint'(win_reg));
		g = (gain_reg > GAIN_ONE) ? 65536 : longint'(gain_reg);
		if (rst)
			clear_history();
		if (fill_cnt >= w) begin
			old_pos = wr_pos - 8'(w);
			run_sum = run_sum - hist[old_pos];
		end
		hist[wr_pos] = x;
		wr_pos = wr_pos + 8'd1;
		if (fill_cnt < 256)
			fill_cnt = fill_cnt + 9'd1;
		run_sum = run_sum + x;
		avg = longint'(run_sum) / w;
		if (rst || !seeded) begin
			exp_state = {x, 16'h0000};
			seeded = 1'b1;
		end else begin
			d = longint'(x) * 65536 - longint'(exp_state);
			exp_state = exp_state + 32'((g * d + 32768) >>> 16);
		end
		y = (longint'(exp_state) + 32768) >>> 16;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return (mode_reg == MODE_EXP) ? y[15:0] : avg[15:0];
	endfunction

	// input driver
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_taken) begin
			in_taken = 1'b0;
			if (in_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				if (s_axis_tready)
					in_gap--;
			end else if (pending_pcm.size() != 0) begin
				pcm_item_t it;
				it = pending_pcm.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= it.pcm;
				s_axis_tuser  <= it.restart;
				if (allow_idle && $urandom_range(0, 3) == 0)
					in_gap = $urandom_range(1, 12);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (out_stall != 0) begin
			m_axis_tready <= 1'b0;
			out_stall--;
		end else if (allow_idle && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			out_stall = $urandom_range(1, 12) - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: check results first, then predict newly taken samples
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_filtered.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected output transfer, filtered=%0d", $realtime,
						$signed(m_axis_tdata));
				mismatches++;
			end else begin
				logic [15:0] want;
				want = expected_filtered.pop_front();
				if (m_axis_tdata !== want) begin
					if (mismatches < 10)
						$display("%0t: filtered mismatch, expected %0d, got %0d", $realtime,
							$signed(want), $signed(m_axis_tdata));
					mismatches++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_filtered.push_back(filter_step(s_axis_tdata, s_axis_tuser));
			in_taken = 1'b1;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_MODE: mode_reg = val[0];
			CFG_WINDOW: begin
				win_reg = val[WREG_W-1:0];
				clear_history();
			end
			CFG_GAIN: gain_reg = val[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_pcm.size() != 0 || s_axis_tvalid || expected_filtered.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	function automatic void push_pcm(input logic signed [15:0] v, input logic rst);
		pcm_item_t it;
		it.pcm     = v;
		it.restart = rst;
		pending_pcm.push_back(it);
	endfunction

	function automatic logic [15:0] rand_pcm();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 64) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_window();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'd256;
			3: return 17'd511;
			4: return 17'($urandom_range(0, 511));
			default: return 17'($urandom_range(2, 24));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return GAIN_ONE;
			2: return 17'h1FFFF;
			3: return 17'($urandom);
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic run_records(input int n, input int restart_odds);
		for (int i = 0; i < n; i++)
			push_pcm(rand_pcm(), restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		allow_idle = 1'b1;

		// reset defaults; first sample seeds the smoother without restart
		push_pcm(16'sh7FFF, 1'b0);
		push_pcm(16'sh7FFF, 1'b0);
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(16'sd0, 1'b0);
		push_pcm(-16'sd1, 1'b0);
		push_pcm(16'sd1, 1'b0);
		push_pcm(-16'sh8000, 1'b1);
		push_pcm(-16'sd1, 1'b0);
		drain();

		cfg_write(CFG_MODE, 17'(MODE_EXP));
		cfg_write(CFG_GAIN, GAIN_ONE);
		push_pcm(16'sh7FFF, 1'b0);
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(16'sd12345, 1'b1);
		drain();

		cfg_write(CFG_GAIN, 17'd0);
		push_pcm(16'sh7FFF, 1'b0);
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(16'sd100, 1'b1);
		push_pcm(-16'sd5, 1'b0);
		drain();

		// zero window acts as one; an oversize gain is also written, in average mode
		cfg_write(CFG_GAIN, 17'h1FFFF);
		cfg_write(CFG_WINDOW, 17'd0);
		cfg_write(CFG_MODE, 17'(MODE_AVG));
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(16'sh7FFF, 1'b0);
		push_pcm(-16'sd3, 1'b0);
		drain();

		// oversize window saturates to full depth
		cfg_write(CFG_WINDOW, 17'd511);
		push_pcm(-16'sh8000, 1'b1);
		push_pcm(-16'sh8000, 1'b0);
		push_pcm(16'sh7FFF, 1'b0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			allow_idle = $urandom_range(0, 2) != 0;
			if (ph == 0 || $urandom_range(0, 1))
				cfg_write(CFG_MODE, 17'($urandom_range(0, 1)));
			if (ph == 0 || $urandom_range(0, 1))
				cfg_write(CFG_WINDOW, rand_window());
			if (ph == 0 || $urandom_range(0, 1))
				cfg_write(CFG_GAIN, rand_gain());
			run_records($urandom_range(5, 15), 20);
		end

		// long record: ring wraps with a full window
		allow_idle = 1'b1;
		cfg_write(CFG_MODE, 17'(MODE_AVG));
		cfg_write(CFG_WINDOW, ($urandom_range(0, 1)) ? 17'd256 : 17'($urandom_range(200, 255)));
		run_records(270, 0);

		allow_idle = 1'b0;
		cfg_write(CFG_MODE, 17'(MODE_EXP));
		cfg_write(CFG_GAIN, rand_gain());
		run_records(30, 10);

		mismatches += expected_filtered.size();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
